// ===== rtl/eabq_pkg.sv =====
// ----------------------------------------------------------------------------
// eabq_pkg
// shared types, codes and the quadrature transition table for the
// encoder and button qualifier
// ----------------------------------------------------------------------------
package eabq_pkg;

   localparam int unsigned TICKS_W = 16;

   localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd100;
   localparam logic [TICKS_W-1:0] COUNT_MAX   = 16'hFFFF;

   // scanned column codes
   localparam logic [1:0] MODE_ENCODER = 2'd0;
   localparam logic [1:0] MODE_BUTTON  = 2'd1;

   typedef enum logic [1:0] {
      EV_PRESSED  = 2'd0,
      EV_RELEASED = 2'd1,
      EV_CW       = 2'd2,
      EV_CCW      = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_CW1  = 3'd1,
      PH_CW2  = 3'd2,
      PH_CW3  = 3'd3,
      PH_CCW1 = 3'd4,
      PH_CCW2 = 3'd5,
      PH_CCW3 = 3'd6
   } phase_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       pin_a;
      logic       pin_b;
   } scan_type;

   typedef struct packed {
      logic      valid;
      event_type code;
   } result_type;

   typedef struct packed {
      phase_type phase;
      logic      emit_cw;
      logic      emit_ccw;
   } quad_type;

   // one step of the quadrature machine, idx is {b, a}
   function automatic quad_type quad_step(input phase_type ph, input logic [1:0] idx);
      quad_type q;
      q.phase    = PH_IDLE;
      q.emit_cw  = 1'b0;
      q.emit_ccw = 1'b0;
      unique case (ph)
         PH_CW1: begin
            unique case (idx)
               2'd0:    q.phase = PH_IDLE;
               2'd1:    q.phase = PH_IDLE;
               2'd2:    q.phase = PH_CW1;
               default: q.phase = PH_CW2;
            endcase
         end
         PH_CW2: begin
            unique case (idx)
               2'd0:    q.phase = PH_IDLE;
               2'd1:    q.phase = PH_CW3;
               2'd2:    q.phase = PH_CW1;
               default: q.phase = PH_CW2;
            endcase
         end
         PH_CW3: begin
            unique case (idx)
               2'd0: begin
                  q.phase   = PH_IDLE;
                  q.emit_cw = 1'b1;
               end
               2'd1:    q.phase = PH_CW3;
               2'd2:    q.phase = PH_IDLE;
               default: q.phase = PH_CW2;
            endcase
         end
         PH_CCW1: begin
            unique case (idx)
               2'd0:    q.phase = PH_IDLE;
               2'd1:    q.phase = PH_CCW1;
               2'd2:    q.phase = PH_IDLE;
               default: q.phase = PH_CCW2;
            endcase
         end
         PH_CCW2: begin
            unique case (idx)
               2'd0:    q.phase = PH_IDLE;
               2'd1:    q.phase = PH_CCW1;
               2'd2:    q.phase = PH_CCW3;
               default: q.phase = PH_CCW2;
            endcase
         end
         PH_CCW3: begin
            unique case (idx)
               2'd0: begin
                  q.phase    = PH_IDLE;
                  q.emit_ccw = 1'b1;
               end
               2'd1:    q.phase = PH_IDLE;
               2'd2:    q.phase = PH_CCW3;
               default: q.phase = PH_CCW2;
            endcase
         end
         default: begin
            // idle, and the unused code behaves as idle
            unique case (idx)
               2'd0:    q.phase = PH_IDLE;
               2'd1:    q.phase = PH_CCW1;
               2'd2:    q.phase = PH_CW1;
               default: q.phase = PH_IDLE;
            endcase
         end
      endcase
      return q;
   endfunction

endpackage

// ===== rtl/eabq_intf.sv =====
// ----------------------------------------------------------------------------
// eabq channel interfaces
// valid/ready channels for scans, events and the debounce register
// ----------------------------------------------------------------------------
interface eabq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic       pin_a;
   logic       pin_b;

   modport source (output valid, output mode, output pin_a, output pin_b, input ready);
   modport sink   (input valid, input mode, input pin_a, input pin_b, output ready);
endinterface

interface eabq_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_code;

   modport source (output valid, output event_code, input ready);
   modport sink   (input valid, input event_code, output ready);
endinterface

interface eabq_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] debounce_ticks;

   modport source (output valid, output debounce_ticks, input ready);
   modport sink   (input valid, input debounce_ticks, output ready);
endinterface

// ===== rtl/eabq_step.sv =====
// ----------------------------------------------------------------------------
// eabq_step
// encoder phase and button debounce state, updated once per scan transfer
// ----------------------------------------------------------------------------
module eabq_step (
   input  logic                                 clock,
   input  logic                                 reset,
   input  eabq_pkg::scan_type                   scan,
   input  logic                                 scan_fire,
   input  logic [eabq_pkg::TICKS_W-1:0]         debounce_ticks,
   output eabq_pkg::result_type                 result
);
   import eabq_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [TICKS_W-1:0] count_ff, count_in;
   logic               level_ff, level_in;
   quad_type           quad;

   assign quad = quad_step(phase_ff, {scan.pin_b, scan.pin_a});

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      level_in     = level_ff;
      result.valid = 1'b0;
      result.code  = EV_CW;
      if (scan.mode == MODE_ENCODER) begin
         phase_in = quad.phase;
         if (quad.emit_cw) begin
            result.valid = 1'b1;
            result.code  = EV_CW;
         end else if (quad.emit_ccw) begin
            result.valid = 1'b1;
            result.code  = EV_CCW;
         end
      end else if (scan.mode == MODE_BUTTON) begin
         level_in = scan.pin_b;
         if (scan.pin_b != level_ff) begin
            count_in = '0;
         end else if (count_ff < debounce_ticks) begin
            count_in = count_ff + 1'b1;
         end else if (count_ff == debounce_ticks && count_ff != COUNT_MAX) begin
            // step once past the limit so the level reports only once
            count_in     = count_ff + 1'b1;
            result.valid = 1'b1;
            result.code  = scan.pin_b ? EV_RELEASED : EV_PRESSED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         level_ff <= 1'b0;
      end else if (scan_fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         level_ff <= level_in;
      end
   end

   // a button event only fires exactly at the limit
   a_button_at_limit: assert property (@(posedge clock) disable iff (reset)
      scan_fire && result.valid && scan.mode == MODE_BUTTON |-> count_ff == debounce_ticks)
      else $error("button event away from the debounce limit");

   // a level change restarts the stable count
   a_change_clears: assert property (@(posedge clock) disable iff (reset)
      scan_fire && scan.mode == MODE_BUTTON && scan.pin_b != level_ff |=> count_ff == '0)
      else $error("stable count not cleared on level change");

   // other columns leave every piece of state alone
   a_other_holds: assert property (@(posedge clock) disable iff (reset)
      scan_fire && scan.mode != MODE_ENCODER && scan.mode != MODE_BUTTON
      |=> $stable(phase_ff) && $stable(count_ff) && $stable(level_ff))
      else $error("state changed on an ignored column");

   // direction events only leave from the last phase of a cycle
   a_dir_from_end: assert property (@(posedge clock) disable iff (reset)
      result.valid && scan.mode == MODE_ENCODER
      |-> (phase_ff == PH_CW3 || phase_ff == PH_CCW3) && quad.phase == PH_IDLE)
      else $error("direction event outside a completed cycle");

endmodule

// ===== rtl/encoder_and_button_qualifier.sv =====
// path: the transfer edge loads the input register, and once the result stage
//   can advance the scan moves through the phase table / debounce counter logic
//   into the event register
// throughput: one scan per clock, a stall on rsp backs up into req ready
// reset: synchronous active-high reset clears both stages, sets the encoder to
//   idle, the stable count and button level to zero and debounce_ticks to 100
// ----------------------------------------------------------------------------
// encoder_and_button_qualifier
// quadrature encoder decoding and push-button debouncing over column scans
// ----------------------------------------------------------------------------
module encoder_and_button_qualifier (
   input  logic           clock,
   input  logic           reset,
   eabq_req_if.sink       req,
   eabq_rsp_if.source     rsp,
   eabq_csr_if.sink       csr
);
   import eabq_pkg::*;

   // debounce limit register, always writable
   logic [TICKS_W-1:0] ticks_ff;

   // input stage
   logic     s1_valid_ff, s1_valid_in;
   scan_type s1_scan_ff;

   // result stage
   logic      rsp_valid_ff, rsp_valid_in;
   event_type rsp_code_ff;

   logic       advance;
   logic       scan_fire;
   result_type result;

   // the result stage moves when it is empty or being taken this cycle
   assign advance   = !rsp_valid_ff || rsp.ready;
   // the input stage empties into the result stage (or vanishes, no event)
   assign scan_fire = s1_valid_ff && advance;
   // input register can take a new transfer when it is empty or draining
   assign req.ready = !s1_valid_ff || advance;

   assign csr.ready = 1'b1;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_code = rsp_code_ff;

   eabq_step u_step (
      .clock          (clock),
      .reset          (reset),
      .scan           (s1_scan_ff),
      .scan_fire      (scan_fire),
      .debounce_ticks (ticks_ff),
      .result         (result)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req.ready) begin
         s1_valid_in = req.valid;
      end
      if (advance) begin
         // scans with no event simply drop out after updating state
         rsp_valid_in = scan_fire && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ticks_ff     <= TICKS_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && csr.ready) begin
            ticks_ff <= csr.debounce_ticks;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         s1_scan_ff.mode  <= req.mode;
         s1_scan_ff.pin_a <= req.pin_a;
         s1_scan_ff.pin_b <= req.pin_b;
      end
      if (advance && scan_fire) begin
         rsp_code_ff <= result.code;
      end
   end

   // a stalled event is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_code_ff))
      else $error("pending event lost under backpressure");

   // an input transfer always lands in the input stage
   a_s1_loaded: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> s1_valid_ff)
      else $error("accepted scan not captured");

   // the input stage never stalls while the output side is free
   a_s1_drains: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_valid_ff |-> scan_fire)
      else $error("scan held although output register is empty");

endmodule
